// File: hdl/tb2sbs_pkg.sv
// Shared types and constants for the top-bottom to side-by-side stereo converter.
// Used by every module of the block; depends on nothing else.
package tb2sbs_pkg;

  localparam int DIM_W      = 14;
  localparam int PLANE_W    = 2;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int OCOL_W     = 13;
  localparam int VAL_W      = 8;
  localparam int FRAME_W    = 13;
  localparam int SKIP_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LINES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_PAIRS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUPLICATE_ROWS = 3'd4;

  localparam logic [FRAME_W-1:0] RESET_FRAME_WIDTH  = 13'd1920;
  localparam logic [FRAME_W-1:0] RESET_FRAME_HEIGHT = 13'd1080;
  localparam logic [SKIP_W-1:0]  RESET_SKIP_LINES   = 12'd0;
  localparam logic               RESET_AVERAGE      = 1'b1;
  localparam logic               RESET_DUPLICATE    = 1'b0;

  localparam logic [PLANE_W-1:0] PLANE_LUMA   = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SKIP_W-1:0] skip;
    logic              average;
    logic              duplicate;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic               hold;
    logic               dup;
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic [OCOL_W-1:0]  col;
    logic [VAL_W-1:0]   value;
  } map_res_t;

endpackage

// File: hdl/stereo_top_bottom_to_side_by_side.sv
// Top-bottom to side-by-side stereo converter for YUV 4:2:0 pixel streams.
// An input pixel is registered, mapped in the following cycle and its writes leave
// from an output register; a pixel waits in the input register while that is busy.
// One pixel is accepted per clock while in_stall is low; the output register
// issues one write per clock while out_stall is low, two per pixel with duplication.
// Pixels that write nothing (held even columns, rows outside both eyes, trailing
// columns) never occupy the output register. Depends on tb2sbs_pkg, tb2sbs_map and
// tb2sbs_out.
module stereo_top_bottom_to_side_by_side #(
  parameter int MAX_WIDTH  = tb2sbs_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = tb2sbs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [tb2sbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tb2sbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tb2sbs_pkg::PLANE_W-1:0]        pixel_plane,
  input  logic [tb2sbs_pkg::ROW_W-1:0]          pixel_row,
  input  logic [tb2sbs_pkg::COL_W-1:0]          pixel_col,
  input  logic [tb2sbs_pkg::VAL_W-1:0]          pixel_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tb2sbs_pkg::PLANE_W-1:0]        out_plane,
  output logic [tb2sbs_pkg::ROW_W-1:0]          out_row,
  output logic [tb2sbs_pkg::OCOL_W-1:0]         out_col,
  output logic [tb2sbs_pkg::VAL_W-1:0]          out_value,
  output logic                                  last_write
);

  localparam int DW = tb2sbs_pkg::DIM_W;
  localparam logic [DW-1:0] WIDTH_LIMIT  = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] HEIGHT_LIMIT = DW'(MAX_HEIGHT);

  logic [tb2sbs_pkg::FRAME_W-1:0]  frame_width;
  logic [tb2sbs_pkg::FRAME_W-1:0]  frame_height;
  logic [tb2sbs_pkg::SKIP_W-1:0]   skip_lines;
  logic                            average_pairs;
  logic                            duplicate_rows;

  logic                            pend_valid;
  logic [tb2sbs_pkg::PLANE_W-1:0]  pend_plane;
  logic [tb2sbs_pkg::ROW_W-1:0]    pend_row;
  logic [tb2sbs_pkg::COL_W-1:0]    pend_col;
  logic [tb2sbs_pkg::VAL_W-1:0]    pend_value;
  logic [tb2sbs_pkg::VAL_W-1:0]    held_pixel;

  tb2sbs_pkg::cfg_t                cfg;
  tb2sbs_pkg::map_res_t            map_res;
  logic                            out_ready;
  logic                            consume;
  logic                            in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= tb2sbs_pkg::RESET_FRAME_WIDTH;
      frame_height   <= tb2sbs_pkg::RESET_FRAME_HEIGHT;
      skip_lines     <= tb2sbs_pkg::RESET_SKIP_LINES;
      average_pairs  <= tb2sbs_pkg::RESET_AVERAGE;
      duplicate_rows <= tb2sbs_pkg::RESET_DUPLICATE;
    end else if (cfg_write) begin
      case (cfg_index)
        tb2sbs_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        tb2sbs_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        tb2sbs_pkg::REG_SKIP_LINES:     skip_lines     <= cfg_data[tb2sbs_pkg::SKIP_W-1:0];
        tb2sbs_pkg::REG_AVERAGE_PAIRS:  average_pairs  <= cfg_data[0];
        tb2sbs_pkg::REG_DUPLICATE_ROWS: duplicate_rows <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.width     = ({1'b0, frame_width} > WIDTH_LIMIT) ? WIDTH_LIMIT : {1'b0, frame_width};
    cfg.height    = ({1'b0, frame_height} > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                                                          : {1'b0, frame_height};
    cfg.skip      = skip_lines;
    cfg.average   = average_pairs;
    cfg.duplicate = duplicate_rows;
  end

  tb2sbs_map u_map (
    .cfg        (cfg),
    .plane      (pend_plane),
    .row        (pend_row),
    .col        (pend_col),
    .value      (pend_value),
    .held_pixel (held_pixel),
    .res        (map_res)
  );

  assign consume  = pend_valid && (!map_res.emit || out_ready);
  assign in_stall = pend_valid && !consume;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      held_pixel <= '0;
    end else begin
      if (in_take) begin
        pend_valid <= 1'b1;
        pend_plane <= pixel_plane;
        pend_row   <= pixel_row;
        pend_col   <= pixel_col;
        pend_value <= pixel_value;
      end else if (consume) begin
        pend_valid <= 1'b0;
      end
      if (consume && map_res.hold) begin
        held_pixel <= pend_value;
      end
    end
  end

  tb2sbs_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (consume && map_res.emit),
    .req        (map_res),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_plane  (out_plane),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .last_write (last_write)
  );

`ifndef ASSERT_OFF
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    !pend_valid |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (consume && map_res.emit) |=> (out_valid && out_row == $past(map_res.row)))
    else $error("write request did not reach the output register");

  a_second_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_write) |=> (out_valid && last_write && out_row[0]))
    else $error("duplicated row write missing");
`endif

endmodule

// File: hdl/tb2sbs_map.sv
// Geometry mapping for one registered input pixel: eye selection, output coordinates
// and pair averaging. Purely combinational; depends on tb2sbs_pkg.
module tb2sbs_map (
  input  tb2sbs_pkg::cfg_t                        cfg,
  input  logic [tb2sbs_pkg::PLANE_W-1:0]          plane,
  input  logic [tb2sbs_pkg::ROW_W-1:0]            row,
  input  logic [tb2sbs_pkg::COL_W-1:0]            col,
  input  logic [tb2sbs_pkg::VAL_W-1:0]            value,
  input  logic [tb2sbs_pkg::VAL_W-1:0]            held_pixel,
  output tb2sbs_pkg::map_res_t                    res
);

  localparam int DW = tb2sbs_pkg::DIM_W;

  logic                                luma;
  logic [DW-1:0]                       half_h;
  logic [DW-1:0]                       half_w;
  logic [tb2sbs_pkg::SKIP_W-1:0]       half_s;
  logic [DW:0]                         n;
  logic [DW-1:0]                       start;
  logic [DW:0]                         row_x;
  logic                                n_pos;
  logic                                in_left;
  logic                                in_right;
  logic                                col_ok;
  logic                                hit;
  logic [tb2sbs_pkg::ROW_W-1:0]        eye_row;
  logic [tb2sbs_pkg::VAL_W:0]          sum;
  logic [tb2sbs_pkg::OCOL_W-1:0]       col_avg;
  logic [tb2sbs_pkg::OCOL_W-1:0]       col_copy;
  logic                                pair_even;

  always_comb begin
    luma   = (plane == tb2sbs_pkg::PLANE_LUMA);
    half_h = luma ? (cfg.height >> 1) : (cfg.height >> 2);
    half_w = luma ? (cfg.width >> 1) : (cfg.width >> 2);
    half_s = luma ? cfg.skip : (cfg.skip >> 1);

    n      = {1'b0, half_h} - {3'b000, half_s};
    start  = half_h + {2'b00, half_s};
    row_x  = {3'b000, row};
    n_pos  = !n[DW] && (n != '0);

    in_left  = (row_x < n);
    in_right = (row_x >= {1'b0, start}) && (row_x < {half_h, 1'b0});
    col_ok   = ({3'b000, col} < {half_w, 1'b0});
    hit      = (plane != tb2sbs_pkg::PLANE_UNUSED) && n_pos && (in_left || in_right) && col_ok;

    eye_row  = in_left ? row : (row - start[tb2sbs_pkg::ROW_W-1:0]);

    sum      = {1'b0, held_pixel} + {1'b0, value};
    col_avg  = {2'b00, col[tb2sbs_pkg::COL_W-1:1]}
             + (in_left ? '0 : half_w[tb2sbs_pkg::OCOL_W-1:0]);
    col_copy = {1'b0, col} + (in_left ? '0 : {half_w[tb2sbs_pkg::OCOL_W-2:0], 1'b0});

    pair_even = cfg.average && !col[0];

    res.emit  = hit && !pair_even;
    res.hold  = hit && pair_even;
    res.dup   = cfg.duplicate;
    res.plane = plane;
    res.row   = cfg.duplicate ? {eye_row[tb2sbs_pkg::ROW_W-2:0], 1'b0} : eye_row;
    res.col   = cfg.average ? col_avg : col_copy;
    res.value = cfg.average ? sum[tb2sbs_pkg::VAL_W:1] : value;
  end

endmodule

// File: hdl/tb2sbs_out.sv
// Output register for write requests; issues one write, or two on consecutive rows
// when row duplication is on. Depends on tb2sbs_pkg.
module tb2sbs_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  tb2sbs_pkg::map_res_t                 req,
  output logic                                 ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [tb2sbs_pkg::PLANE_W-1:0]       out_plane,
  output logic [tb2sbs_pkg::ROW_W-1:0]         out_row,
  output logic [tb2sbs_pkg::OCOL_W-1:0]        out_col,
  output logic [tb2sbs_pkg::VAL_W-1:0]         out_value,
  output logic                                 last_write
);

  logic out_take;

  assign out_take = out_valid && !out_stall;
  assign ready    = !out_valid || (out_take && last_write);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_write <= 1'b0;
    end else if (load) begin
      out_valid  <= 1'b1;
      last_write <= !req.dup;
      out_plane  <= req.plane;
      out_row    <= req.row;
      out_col    <= req.col;
      out_value  <= req.value;
    end else if (out_take && !last_write) begin
      out_row[0] <= 1'b1;
      last_write <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: test/stereo_sbs_checker.sv
// Checker for the top-bottom to side-by-side stereo converter: follows register writes
// and accepted pixel requests, predicts the output writes and compares them in order.
// Depends on tb2sbs_pkg.
module stereo_sbs_checker
  import tb2sbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PLANE_W-1:0]    pixel_plane,
  input  logic [ROW_W-1:0]      pixel_row,
  input  logic [COL_W-1:0]      pixel_col,
  input  logic [VAL_W-1:0]      pixel_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [PLANE_W-1:0]    out_plane,
  input  logic [ROW_W-1:0]      out_row,
  input  logic [OCOL_W-1:0]     out_col,
  input  logic [VAL_W-1:0]      out_value,
  input  logic                  last_write,
  output int                    mismatches,
  output int                    pending_writes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PLANE_W-1:0] plane;
    logic [ROW_W-1:0]   row;
    logic [OCOL_W-1:0]  col;
    logic [VAL_W-1:0]   value;
    logic               last;
  } sbs_write_t;

  sbs_write_t         expected_writes[$];
  logic [FRAME_W-1:0] width_reg;
  logic [FRAME_W-1:0] height_reg;
  logic [SKIP_W-1:0]  skip_reg;
  logic               average_reg;
  logic               duplicate_reg;
  logic [VAL_W-1:0]   held_sample;
  int                 error_count = 0;

  initial pending_writes = 0;
  assign mismatches = error_count;

  task automatic report(input string msg);
    error_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic place_pixel(input logic [PLANE_W-1:0] plane, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value);
    int               w;
    int               h;
    int               s;
    int               rows;
    int               eye_start;
    int               half;
    int               eye_row;
    int               col_out;
    logic [VAL_W:0]   pair_sum;
    logic [VAL_W-1:0] value_out;
    sbs_write_t       wr;
    w = (int'(width_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    h = (int'(height_reg) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
    s = int'(skip_reg);
    if (plane == PLANE_UNUSED) return;
    if (plane == PLANE_LUMA) begin
      rows = h / 2 - s;
      eye_start = h / 2 + s;
      half = w / 2;
    end else begin
      rows = h / 4 - s / 2;
      eye_start = h / 4 + s / 2;
      half = w / 4;
    end
    if (rows <= 0) return;
    if (int'(row) < rows) begin
      eye_row = int'(row);
      eye_start = 0;
      half = (int'(col) >= 2 * half) ? -1 : half;
      if (half < 0) return;
      col_out = average_reg ? int'(col) / 2 : int'(col);
    end else if (int'(row) >= eye_start && int'(row) < eye_start + rows) begin
      eye_row = int'(row) - eye_start;
      if (int'(col) >= 2 * half) return;
      col_out = average_reg ? int'(col) / 2 + half : int'(col) + 2 * half;
    end else begin
      return;
    end
    if (average_reg) begin
      if (!col[0]) begin
        held_sample = value;
        return;
      end
      pair_sum = {1'b0, held_sample} + {1'b0, value};
      value_out = pair_sum[VAL_W:1];
    end else begin
      value_out = value;
    end
    wr.plane = plane;
    wr.col = OCOL_W'(col_out);
    wr.value = value_out;
    if (duplicate_reg) begin
      for (int k = 0; k < 2; k++) begin
        wr.row = ROW_W'(2 * eye_row + k);
        wr.last = (k == 1);
        expected_writes.push_back(wr);
      end
    end else begin
      wr.row = ROW_W'(eye_row);
      wr.last = 1'b1;
      expected_writes.push_back(wr);
    end
  endtask

  task automatic check_write();
    sbs_write_t want;
    if (expected_writes.size() == 0) begin
      report($sformatf("unexpected write plane %0d row %0d col %0d value %0d",
                       out_plane, out_row, out_col, out_value));
      return;
    end
    want = expected_writes.pop_front();
    if (out_plane !== want.plane)
      report($sformatf("out_plane %0d, expected %0d", out_plane, want.plane));
    if (out_row !== want.row)
      report($sformatf("out_row %0d, expected %0d", out_row, want.row));
    if (out_col !== want.col)
      report($sformatf("out_col %0d, expected %0d", out_col, want.col));
    if (out_value !== want.value)
      report($sformatf("out_value %0d, expected %0d", out_value, want.value));
    if (last_write !== want.last)
      report($sformatf("last_write %0d, expected %0d", last_write, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = RESET_FRAME_WIDTH;
      height_reg = RESET_FRAME_HEIGHT;
      skip_reg = RESET_SKIP_LINES;
      average_reg = RESET_AVERAGE;
      duplicate_reg = RESET_DUPLICATE;
      held_sample = '0;
      expected_writes.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:    width_reg = cfg_data[FRAME_W-1:0];
          REG_FRAME_HEIGHT:   height_reg = cfg_data[FRAME_W-1:0];
          REG_SKIP_LINES:     skip_reg = cfg_data[SKIP_W-1:0];
          REG_AVERAGE_PAIRS:  average_reg = cfg_data[0];
          REG_DUPLICATE_ROWS: duplicate_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_write();
      if (in_valid && !in_stall) place_pixel(pixel_plane, pixel_row, pixel_col, pixel_value);
    end
    pending_writes <= expected_writes.size();
  end

endmodule

// File: test/tb_stereo_top_bottom_to_side_by_side.sv
// Testbench top for the top-bottom to side-by-side stereo converter: drives pixel
// requests and register writes, stalls the output at random and gives the verdict.
// Depends on tb2sbs_pkg, the block and stereo_sbs_checker.
module tb_stereo_top_bottom_to_side_by_side;
  timeunit 1ns;
  timeprecision 1ps;
  import tb2sbs_pkg::*;

  localparam logic [PLANE_W-1:0] PLANE_CHROMA_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CHROMA_V = 2'd2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PLANE_W-1:0]    pixel_plane = '0;
  logic [ROW_W-1:0]      pixel_row = '0;
  logic [COL_W-1:0]      pixel_col = '0;
  logic [VAL_W-1:0]      pixel_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PLANE_W-1:0]    out_plane;
  logic [ROW_W-1:0]      out_row;
  logic [OCOL_W-1:0]     out_col;
  logic [VAL_W-1:0]      out_value;
  logic                  last_write;
  int                    mismatches;
  int                    pending_writes;
  int                    tx_idle_pct = 27;
  int                    rx_idle_pct = 88;
  int                    cur_w = RESET_FRAME_WIDTH;
  int                    cur_h = RESET_FRAME_HEIGHT;
  int                    cur_s = RESET_SKIP_LINES;

  stereo_top_bottom_to_side_by_side uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_plane(pixel_plane), .pixel_row(pixel_row), .pixel_col(pixel_col),
    .pixel_value(pixel_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_plane(out_plane), .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .last_write(last_write)
  );

  stereo_sbs_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_plane(pixel_plane), .pixel_row(pixel_row), .pixel_col(pixel_col),
    .pixel_value(pixel_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_plane(out_plane), .out_row(out_row), .out_col(out_col), .out_value(out_value),
    .last_write(last_write),
    .mismatches(mismatches), .pending_writes(pending_writes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_pixel(input int plane, input int row, input int col, input int value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_plane <= PLANE_W'(plane);
    pixel_row <= ROW_W'(row);
    pixel_col <= COL_W'(col);
    pixel_value <= VAL_W'(value);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input int w, input int h, input int s, input int average,
                               input int duplicate);
    logic [CFG_IDX_W-1:0] idx [5];
    int                   val [5];
    idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_SKIP_LINES, REG_AVERAGE_PAIRS,
            REG_DUPLICATE_ROWS};
    val = '{w, h, s, average, duplicate};
    drain();
    for (int i = 0; i < 5; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= CFG_DATA_W'(val[i]);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_w = w;
    cur_h = h;
    cur_s = s;
  endtask

  // Mostly even/odd pairs inside the plane, plus lone samples, rows and columns
  // around the eye edges, and unconstrained noise.
  task automatic run_random(input int target);
    int sent;
    int pl;
    int plane_h;
    int plane_w;
    int sk;
    int kind;
    int r;
    int c;
    int base;
    sent = 0;
    while (sent < target) begin
      pl = $urandom_range(2);
      plane_h = ((cur_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cur_h) >> (pl != 0);
      plane_w = ((cur_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cur_w) >> (pl != 0);
      if (plane_h < 1) plane_h = 1;
      if (plane_w < 2) plane_w = 2;
      sk = cur_s >> (pl != 0);
      kind = $urandom_range(99);
      if ($urandom_range(149) == 0) drain();
      if (kind < 60) begin
        r = $urandom_range(plane_h - 1);
        c = 2 * $urandom_range(plane_w / 2 - 1);
        send_pixel(pl, r, c, $urandom_range(255));
        send_pixel(pl, r, c + 1, $urandom_range(255));
        sent += 2;
      end else if (kind < 72) begin
        send_pixel(pl, $urandom_range(plane_h - 1), $urandom_range(plane_w - 1),
                   $urandom_range(255));
        sent++;
      end else if (kind < 86) begin
        case ($urandom_range(3))
          0: base = plane_h / 2 - sk;
          1: base = plane_h / 2 + sk;
          2: base = plane_h;
          default: base = 0;
        endcase
        r = base + int'($urandom_range(4)) - 2;
        c = plane_w + int'($urandom_range(3)) - 2;
        send_pixel(pl, r & 12'hFFF, c & 12'hFFF, $urandom_range(255));
        sent++;
      end else begin
        send_pixel($urandom_range(3), $urandom, $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 1920x1080, no skip, averaging on, no row duplication.
    send_pixel(PLANE_LUMA, 0, 1, 255);
    send_pixel(PLANE_LUMA, 0, 0, 200);
    send_pixel(PLANE_LUMA, 0, 1, 101);
    send_pixel(PLANE_LUMA, 539, 1918, 0);
    send_pixel(PLANE_LUMA, 539, 1919, 255);
    send_pixel(PLANE_LUMA, 540, 0, 255);
    send_pixel(PLANE_LUMA, 540, 1, 255);
    send_pixel(PLANE_LUMA, 1079, 1919, 7);
    send_pixel(PLANE_LUMA, 1080, 1, 9);
    send_pixel(PLANE_LUMA, 4095, 4095, 9);
    send_pixel(PLANE_LUMA, 10, 1920, 1);
    send_pixel(PLANE_LUMA, 10, 1921, 2);
    send_pixel(PLANE_LUMA, 5, 100, 10);
    send_pixel(PLANE_UNUSED, 5, 101, 250);
    send_pixel(PLANE_LUMA, 5, 101, 20);
    send_pixel(PLANE_CHROMA_U, 269, 958, 40);
    send_pixel(PLANE_CHROMA_U, 269, 959, 60);
    send_pixel(PLANE_CHROMA_V, 270, 0, 0);
    send_pixel(PLANE_CHROMA_V, 270, 1, 1);
    send_pixel(PLANE_CHROMA_V, 540, 1, 3);

    // Oversized frame registers saturate; copies with duplicated rows.
    load_settings(8191, 8191, 100, 0, 1);
    send_pixel(PLANE_LUMA, 0, 0, 0);
    send_pixel(PLANE_LUMA, 2148, 4095, 255);
    send_pixel(PLANE_LUMA, 1947, 4095, 128);
    send_pixel(PLANE_CHROMA_U, 1074, 2047, 77);

    load_settings(64, 48, 4, 1, 0);
    run_random(150);
    load_settings(2, 2, 0, 1, 1);
    run_random(100);

    tx_idle_pct = 88;
    rx_idle_pct = 27;
    load_settings(4096, 4096, 0, 0, 1);
    run_random(150);
    load_settings(8191, 8191, 4095, 0, 0);
    run_random(30);
    load_settings(37, 29, 3, 1, 1);
    run_random(150);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_settings(100, 300, 1, 0, 0);
    run_random(150);
    load_settings(1000, 10, 2, 1, 0);
    run_random(150);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_writes == 0) begin
      $display("** stereo_top_bottom_to_side_by_side: PASSED **");
    end else begin
      $display("** stereo_top_bottom_to_side_by_side: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** stereo_top_bottom_to_side_by_side: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
hdl/tb2sbs_pkg.sv
hdl/tb2sbs_map.sv
hdl/tb2sbs_out.sv
hdl/stereo_top_bottom_to_side_by_side.sv
test/stereo_sbs_checker.sv
test/tb_stereo_top_bottom_to_side_by_side.sv
